// File: design/display_idle_off_tap_wake_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the display idle-off / tap-wake core
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_IDLE_OFF_TAP_WAKE_CORE_ASSERT_SVH
`define DISPLAY_IDLE_OFF_TAP_WAKE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DIOTW_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DIOTW_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DIOTW_ASSERT_IMP(label, ante, cons, msg)
`define DIOTW_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// File: design/diotw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diotw_pkg
// Shared types and constants of the display idle-off / tap-wake core.
// ----------------------------------------------------------------------------
package diotw_pkg;

	localparam int TICK_WIDTH_DEF = 32;
	localparam int OPCODE_W       = 3;
	localparam int NOW_W          = 32;
	localparam int ACTION_W       = 2;
	localparam int CFG_W          = 32;
	localparam int PADDR_W        = 4;
	localparam int PDATA_W        = 32;

	// event opcodes
	localparam logic [OPCODE_W-1:0] OP_POLL     = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_ACTIVITY = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_FORCE_ON = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_PRESS    = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_RELEASE  = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_LOST     = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SHORT    = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_DOUBLE   = 3'd7;

	// backlight actions
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_OFF  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_ON   = 2'd2;

	// register indexes (word address)
	localparam logic [1:0] REG_AUTO_OFF   = 2'd0;
	localparam logic [1:0] REG_IDLE_TMO   = 2'd1;
	localparam logic [1:0] REG_MAX_TAP    = 2'd2;
	localparam logic [1:0] REG_TAP_WINDOW = 2'd3;

	// register reset values
	localparam logic             RST_AUTO_OFF   = 1'b1;
	localparam logic [CFG_W-1:0] RST_IDLE_TMO   = 32'd10000;
	localparam logic [CFG_W-1:0] RST_MAX_TAP    = 32'd300;
	localparam logic [CFG_W-1:0] RST_TAP_WINDOW = 32'd700;

	typedef struct packed {
		logic             auto_off_enable;
		logic [CFG_W-1:0] idle_timeout_ticks;
		logic [CFG_W-1:0] max_tap_ticks;
		logic [CFG_W-1:0] double_tap_window_ticks;
	} cfg_t;

endpackage

// File: design/diotw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diotw_if
// Valid/ready channels for event items and result items.
// ----------------------------------------------------------------------------
interface diotw_evt_if import diotw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [NOW_W-1:0]    now_tick;
	logic                recording;

	modport source (output valid, opcode, now_tick, recording, input ready);
	modport sink   (input valid, opcode, now_tick, recording, output ready);
endinterface

interface diotw_res_if import diotw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                display_is_off;
	logic [ACTION_W-1:0] backlight_action;

	modport source (output valid, display_is_off, backlight_action, input ready);
	modport sink   (input valid, display_is_off, backlight_action, output ready);
endinterface

// File: design/display_idle_off_tap_wake_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_idle_off_tap_wake_core
// Backlight idle timeout with a double-tap wake guard while recording.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------
//  evt      | in  | valid/ready   | opcode, now_tick, recording
//  res      | out | valid/ready   | display_is_off, backlight_action
//  apb      | in  | psel/penable  | paddr, pwdata, prdata (4 registers)
//
//  One item per cycle sustained while res takes each result item.
//  An item sits in the input register, then one pass of subtract/compare
//  logic updates the state and loads the result register at the same edge.
//  evt.ready drops only when the input register is full and the result
//  register holds an item that res has not taken.
//  arst_n clears the state flags and last_q, the valid flags, and sets the registers to defaults.
//
`include "display_idle_off_tap_wake_core_assert.svh"

module display_idle_off_tap_wake_core import diotw_pkg::*; #(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	diotw_evt_if.sink          evt,
	diotw_res_if.source        res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// compare width: ticks against 32-bit limits
	localparam int CW = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;

	cfg_t cfg;

	diotw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	logic                  valid_s1;
	logic [OPCODE_W-1:0]   op_s1;
	logic [TICK_WIDTH-1:0] now_s1;
	logic                  rec_s1;

	// result register
	logic                res_valid_q;
	logic                res_off_q;
	logic [ACTION_W-1:0] res_act_q;

	// block state
	logic                  off_q;
	logic [TICK_WIDTH-1:0] last_q;
	logic                  seen_q;
	logic [TICK_WIDTH-1:0] pstart_q;
	logic                  ppend_q;
	logic [TICK_WIDTH-1:0] ftap_q;
	logic                  ftseen_q;

	logic adv;
	logic take;

	assign adv       = valid_s1 & (~res_valid_q | res.ready);
	assign evt.ready = ~valid_s1 | adv;
	assign take      = evt.valid & evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= evt.opcode;
			now_s1 <= TICK_WIDTH'(evt.now_tick);
			rec_s1 <= evt.recording;
		end
	end

	// elapsed times and limit compares
	logic [TICK_WIDTH-1:0] idle_el;
	logic [TICK_WIDTH-1:0] dur_el;
	logic [TICK_WIDTH-1:0] gap_el;
	logic                  idle_hit;
	logic                  tap_ok;
	logic                  win_ok;

	assign idle_el  = seen_q ? (now_s1 - last_q) : '0;
	assign dur_el   = now_s1 - pstart_q;
	assign gap_el   = now_s1 - ftap_q;
	assign idle_hit = CW'(idle_el) >= CW'(cfg.idle_timeout_ticks);
	assign tap_ok   = CW'(dur_el) <= CW'(cfg.max_tap_ticks);
	assign win_ok   = ftseen_q & (CW'(gap_el) <= CW'(cfg.double_tap_window_ticks));

	// next state for one event
	logic                  off_d;
	logic [TICK_WIDTH-1:0] last_d;
	logic                  seen_d;
	logic [TICK_WIDTH-1:0] pstart_d;
	logic                  ppend_d;
	logic [TICK_WIDTH-1:0] ftap_d;
	logic                  ftseen_d;
	logic [ACTION_W-1:0]   act_d;
	logic                  wake;
	logic                  clr;

	always_comb begin
		off_d    = off_q;
		last_d   = last_q;
		seen_d   = seen_q;
		pstart_d = pstart_q;
		ppend_d  = ppend_q;
		ftap_d   = ftap_q;
		ftseen_d = ftseen_q;
		act_d    = ACT_NONE;
		wake     = 1'b0;
		clr      = 1'b0;

		case (op_s1)
			OP_POLL: begin
				if (cfg.auto_off_enable && !off_q) begin
					if (!seen_q) begin
						last_d = now_s1;
						seen_d = 1'b1;
					end
					if (idle_hit) begin
						off_d = 1'b1;
						clr   = 1'b1;
						act_d = ACT_OFF;
					end
				end
			end
			OP_ACTIVITY: begin
				last_d = now_s1;
				seen_d = 1'b1;
			end
			OP_FORCE_ON: wake = 1'b1;
			default: begin
				if (!off_q) begin
					// touch while on
					if (op_s1 == OP_PRESS) begin
						last_d = now_s1;
						seen_d = 1'b1;
					end
					clr = 1'b1;
				end else if (!rec_s1) begin
					// off, no guard: any press wakes
					clr  = 1'b1;
					wake = (op_s1 == OP_PRESS);
				end else begin
					// off and recording: tap guard
					case (op_s1)
						OP_LOST: clr = 1'b1;
						OP_PRESS: begin
							pstart_d = now_s1;
							ppend_d  = 1'b1;
						end
						OP_DOUBLE: wake = 1'b1;
						OP_SHORT: begin
							if (!ppend_q || !tap_ok) begin
								clr = 1'b1;
							end else if (win_ok) begin
								wake = 1'b1;
							end else begin
								ppend_d  = 1'b0;
								ftap_d   = now_s1;
								ftseen_d = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
		endcase

		if (clr || wake) begin
			ppend_d  = 1'b0;
			ftseen_d = 1'b0;
		end
		if (wake) begin
			off_d  = 1'b0;
			last_d = now_s1;
			seen_d = 1'b1;
			act_d  = off_q ? ACT_ON : ACT_NONE;
		end
	end

	// state and result update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q    <= 1'b0;
			seen_q   <= 1'b0;
			ppend_q  <= 1'b0;
			ftseen_q <= 1'b0;
			last_q   <= '0;
		end else if (adv) begin
			off_q    <= off_d;
			seen_q   <= seen_d;
			ppend_q  <= ppend_d;
			ftseen_q <= ftseen_d;
			last_q   <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pstart_q  <= pstart_d;
			ftap_q    <= ftap_d;
			res_off_q <= off_d;
			res_act_q <= act_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.display_is_off   = res_off_q;
	assign res.backlight_action = res_act_q;

	// checks
	`DIOTW_ASSERT_IMP(a_on_means_lit, res_valid_q && res_act_q == ACT_ON, !res_off_q, "switch-on result shows the display off")
	`DIOTW_ASSERT_IMP(a_off_means_dark, res_valid_q && res_act_q == ACT_OFF, res_off_q, "switch-off result shows the display on")
	`DIOTW_ASSERT_IMP(a_rise_gives_off, $rose(off_q), res_valid_q && res_act_q == ACT_OFF, "display went off without a switch-off result")
	`DIOTW_ASSERT_IMP(a_guard_only_off, ppend_q || ftseen_q, off_q, "tap guard armed while the display is on")
	`DIOTW_ASSERT_NXT(a_stall_holds, res_valid_q && !res.ready, res_valid_q && $stable(res_act_q) && $stable(off_q), "result or state changed during an output stall")

endmodule

// File: design/diotw_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diotw_regs
// APB-style configuration registers; zero wait states.
// ----------------------------------------------------------------------------
module diotw_regs import diotw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_off_enable         <= RST_AUTO_OFF;
			cfg_q.idle_timeout_ticks      <= RST_IDLE_TMO;
			cfg_q.max_tap_ticks           <= RST_MAX_TAP;
			cfg_q.double_tap_window_ticks <= RST_TAP_WINDOW;
		end else if (wr_en) begin
			case (reg_idx)
				REG_AUTO_OFF:   cfg_q.auto_off_enable         <= pwdata[0];
				REG_IDLE_TMO:   cfg_q.idle_timeout_ticks      <= pwdata[CFG_W-1:0];
				REG_MAX_TAP:    cfg_q.max_tap_ticks           <= pwdata[CFG_W-1:0];
				REG_TAP_WINDOW: cfg_q.double_tap_window_ticks <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_AUTO_OFF:   prdata = {{(PDATA_W-1){1'b0}}, cfg_q.auto_off_enable};
			REG_IDLE_TMO:   prdata = cfg_q.idle_timeout_ticks;
			REG_MAX_TAP:    prdata = cfg_q.max_tap_ticks;
			REG_TAP_WINDOW: prdata = cfg_q.double_tap_window_ticks;
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: tb/display_idle_off_tap_wake_core_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_idle_off_tap_wake_core_chk
// Passive checker that predicts each backlight result and compares it.
// It follows register writes on the APB port, computes the backlight state
// and action for every accepted event item, and checks each result item
// against the oldest prediction.
// ----------------------------------------------------------------------------
module display_idle_off_tap_wake_core_chk import diotw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	diotw_evt_if               evt,
	diotw_res_if               res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int unsigned        err_cnt,
	output int unsigned        backlog,
	output int unsigned        checked_cnt,
	output int unsigned        off_cnt,
	output int unsigned        on_cnt
);

	typedef struct packed {
		logic                off;
		logic [ACTION_W-1:0] act;
	} backlight_t;

	backlight_t expected_q[$];

	// predicted register file and block state
	cfg_t             cfg;
	logic             is_off;
	logic [NOW_W-1:0] last_touch;
	logic             seen_activity;
	logic [NOW_W-1:0] press_t;
	logic             press_pend;
	logic [NOW_W-1:0] tap1_t;
	logic             tap1_seen;

	int unsigned errs    = 0;
	int unsigned n_check = 0;
	int unsigned n_off   = 0;
	int unsigned n_on    = 0;

	function automatic void clear_tap_guard();
		tap1_t     = '0;
		tap1_seen  = 1'b0;
		press_t    = '0;
		press_pend = 1'b0;
	endfunction

	function automatic void note_activity(input logic [NOW_W-1:0] now);
		last_touch    = now;
		seen_activity = 1'b1;
	endfunction

	// wake or force on; action only if the display was off
	function automatic logic [ACTION_W-1:0] wake_up(input logic [NOW_W-1:0] now);
		logic [ACTION_W-1:0] a;
		a = is_off ? ACT_ON : ACT_NONE;
		is_off = 1'b0;
		clear_tap_guard();
		note_activity(now);
		return a;
	endfunction

	function automatic backlight_t predict_backlight(input logic [OPCODE_W-1:0] op,
			input logic [NOW_W-1:0] now, input logic rec);
		logic [ACTION_W-1:0] act;
		logic [NOW_W-1:0]    span;
		backlight_t          r;
		act = ACT_NONE;
		case (op)
			OP_POLL: begin
				if (cfg.auto_off_enable && !is_off) begin
					if (!seen_activity)
						note_activity(now);
					span = now - last_touch;
					if (span >= cfg.idle_timeout_ticks) begin
						is_off = 1'b1;
						clear_tap_guard();
						act = ACT_OFF;
					end
				end
			end
			OP_ACTIVITY: note_activity(now);
			OP_FORCE_ON: act = wake_up(now);
			default: begin
				if (!is_off) begin
					// touch while lit: press counts as activity
					if (op == OP_PRESS)
						note_activity(now);
					clear_tap_guard();
				end else if (!rec) begin
					clear_tap_guard();
					if (op == OP_PRESS)
						act = wake_up(now);
				end else begin
					// off and recording: only a double tap wakes
					case (op)
						OP_LOST: clear_tap_guard();
						OP_PRESS: begin
							press_t    = now;
							press_pend = 1'b1;
						end
						OP_DOUBLE: act = wake_up(now);
						OP_SHORT: begin
							if (!press_pend) begin
								clear_tap_guard();
							end else begin
								span       = now - press_t;
								press_t    = '0;
								press_pend = 1'b0;
								if (span > cfg.max_tap_ticks) begin
									clear_tap_guard();
								end else if (tap1_seen &&
										NOW_W'(now - tap1_t) <= cfg.double_tap_window_ticks) begin
									act = wake_up(now);
								end else begin
									tap1_t    = now;
									tap1_seen = 1'b1;
								end
							end
						end
						default: ; // release: no change
					endcase
				end
			end
		endcase
		r.off = is_off;
		r.act = act;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : backlight_check
		backlight_t want;
		if (!arst_n) begin
			cfg.auto_off_enable         = RST_AUTO_OFF;
			cfg.idle_timeout_ticks      = RST_IDLE_TMO;
			cfg.max_tap_ticks           = RST_MAX_TAP;
			cfg.double_tap_window_ticks = RST_TAP_WINDOW;
			is_off        = 1'b0;
			last_touch    = '0;
			seen_activity = 1'b0;
			clear_tap_guard();
			expected_q.delete();
			backlog <= 0;
		end else begin
			// compare the result item first, so an early one is never masked
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result item: display_is_off %0b backlight_action %0d",
						res.display_is_off, res.backlight_action);
					errs++;
				end else begin
					want = expected_q.pop_front();
					n_check++;
					if (res.display_is_off !== want.off) begin
						$error("display_is_off: expected %0b, got %0b",
							want.off, res.display_is_off);
						errs++;
					end
					if (res.backlight_action !== want.act) begin
						$error("backlight_action: expected %0d, got %0d",
							want.act, res.backlight_action);
						errs++;
					end
					if (want.act == ACT_OFF)
						n_off++;
					if (want.act == ACT_ON)
						n_on++;
				end
			end
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_AUTO_OFF:   cfg.auto_off_enable         = pwdata[0];
					REG_IDLE_TMO:   cfg.idle_timeout_ticks      = pwdata;
					REG_MAX_TAP:    cfg.max_tap_ticks           = pwdata;
					REG_TAP_WINDOW: cfg.double_tap_window_ticks = pwdata;
					default: ;
				endcase
			end
			if (evt.valid && evt.ready)
				expected_q.push_back(predict_backlight(evt.opcode, evt.now_tick,
					evt.recording));
			backlog <= expected_q.size();
		end
		err_cnt     <= errs;
		checked_cnt <= n_check;
		off_cnt     <= n_off;
		on_cnt      <= n_on;
	end

endmodule

// File: tb/display_idle_off_tap_wake_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_idle_off_tap_wake_core_tb
// Stimulus and verdict for the display idle-off / tap-wake core.
// Directed events hit the timeout and tap-guard corner cases, then random
// scenes (idle-off, tap sequences while recording, plain wakes, noise) run
// under several register settings with random gaps and result stalls.
// ----------------------------------------------------------------------------
module display_idle_off_tap_wake_core_tb;
	import diotw_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	diotw_evt_if evt_ch ();
	diotw_res_if res_ch ();

	int unsigned err_cnt, backlog, checked_cnt, off_cnt, on_cnt;
	int unsigned sent_cnt = 0;
	bit          no_idle = 1'b0;

	// running tick of the random scenes and the programmed registers
	logic [NOW_W-1:0] tk;
	logic [CFG_W-1:0] cur_tmo  = RST_IDLE_TMO;
	logic [CFG_W-1:0] cur_max  = RST_MAX_TAP;
	logic [CFG_W-1:0] cur_win  = RST_TAP_WINDOW;

	display_idle_off_tap_wake_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	display_idle_off_tap_wake_core_chk chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt         (evt_ch),
		.res         (res_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.err_cnt     (err_cnt),
		.backlog     (backlog),
		.checked_cnt (checked_cnt),
		.off_cnt     (off_cnt),
		.on_cnt      (on_cnt)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: random stall before taking each item
	always begin : result_sink
		int stall;
		stall = no_idle ? 0 : $urandom_range(0, 3);
		if (stall > 0) begin
			res_ch.ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
		res_ch.ready <= 1'b1;
		do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
	end

	// one event item; valid stays high afterwards until the next gap or pause
	task automatic send(input logic [OPCODE_W-1:0] op, input logic [NOW_W-1:0] now,
			input logic rec);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid     <= 1'b1;
		evt_ch.opcode    <= op;
		evt_ch.now_tick  <= now;
		evt_ch.recording <= rec;
		do @(posedge clk); while (!evt_ch.ready);
		sent_cnt++;
	endtask

	// stop sending and wait for every outstanding result
	task automatic pause_until_drained();
		evt_ch.valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_config(input logic auto, input logic [CFG_W-1:0] tmo,
			input logic [CFG_W-1:0] mx, input logic [CFG_W-1:0] win);
		pause_until_drained();
		cfg_write(REG_AUTO_OFF, {{(PDATA_W-1){1'b0}}, auto});
		cfg_write(REG_IDLE_TMO, tmo);
		cfg_write(REG_MAX_TAP, mx);
		cfg_write(REG_TAP_WINDOW, win);
		cur_tmo  = tmo;
		cur_max  = mx;
		cur_win  = win;
	endtask

	// a value within two ticks of a threshold, wrapping
	function automatic logic [NOW_W-1:0] near(input logic [NOW_W-1:0] thr);
		logic [NOW_W-1:0] j;
		j = $urandom_range(0, 4);
		return thr + j - 2;
	endfunction

	function automatic logic [NOW_W-1:0] pick_dur();
		case ($urandom_range(0, 3))
			0:       return near(cur_max);
			1, 2:    return $urandom_range(0, (cur_max > 1000) ? 1000 : cur_max);
			default: return $urandom;
		endcase
	endfunction

	// idle the display off (unless auto-off is disabled or timing just misses)
	task automatic go_off(input logic rec);
		tk += $urandom_range(1, 20);
		send(OP_ACTIVITY, tk, rec);
		tk += near(cur_tmo);
		send(OP_POLL, tk, rec);
	endtask

	// press then short click, sometimes a release inside or a lost press instead
	task automatic tap(input logic [NOW_W-1:0] dur, input logic rec);
		send(OP_PRESS, tk, rec);
		if ($urandom_range(0, 3) == 0)
			send(OP_RELEASE, tk + dur / 2, rec);
		tk += dur;
		send(($urandom_range(0, 11) == 0) ? OP_LOST : OP_SHORT, tk, rec);
	endtask

	task automatic run_random(input int unsigned n);
		int unsigned      stop_at;
		logic [NOW_W-1:0] d1, d2, gap;
		stop_at = sent_cnt + n;
		while (sent_cnt < stop_at) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 19) == 0)
				tk = 32'hFFFF_FFFF - $urandom_range(0, 2000);
			if ($urandom_range(0, 29) == 0)
				pause_until_drained();
			case ($urandom_range(0, 19))
				// double tap attempts while off and recording
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
					if ($urandom_range(0, 2) != 0)
						go_off(1'b1);
					repeat ($urandom_range(1, 2)) begin
						d1 = pick_dur();
						tk += $urandom_range(1, 100);
						tap(d1, 1'b1);
						d2 = pick_dur();
						case ($urandom_range(0, 3))
							0, 1:    gap = near(cur_win);
							2:       gap = $urandom_range(0, (cur_win > 2000) ? 2000 : cur_win);
							default: gap = $urandom;
						endcase
						tk += gap - d2;
						tap(d2, 1'b1);
					end
				end
				// plain touch while off and not recording
				12, 13, 14: begin
					go_off(1'($urandom_range(0, 1)));
					tk += $urandom_range(0, 50);
					send(OPCODE_W'($urandom_range(OP_PRESS, OP_DOUBLE)), tk, 1'b0);
				end
				// noise
				default: begin
					repeat ($urandom_range(1, 6)) begin
						tk += ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 300);
						send(OPCODE_W'($urandom_range(0, 7)), tk, 1'($urandom_range(0, 1)));
					end
				end
			endcase
		end
	endtask

	initial begin
		#2_000_000;
		$display("display_idle_off_tap_wake_core_tb failed");
		$finish;
	end

	initial begin
		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		evt_ch.valid     <= 1'b0;
		evt_ch.opcode    <= OP_POLL;
		evt_ch.now_tick  <= '0;
		evt_ch.recording <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners at reset settings (timeout 10000, tap 300, window 700)
		send(OP_POLL, 32'hFFFF_FF00, 1'b0);     // first poll only records time
		send(OP_POLL, 32'd9743, 1'b0);          // 9999 after wrap: stays on
		send(OP_POLL, 32'd9744, 1'b1);          // exactly the timeout: off
		send(OP_POLL, 32'hFFFF_FFFF, 1'b1);     // already off
		send(OP_RELEASE, 32'd9800, 1'b0);       // non-press touch does not wake
		send(OP_PRESS, 32'd9900, 1'b0);         // press wakes when not recording
		send(OP_FORCE_ON, 32'd0, 1'b1);         // force on while on
		send(OP_DOUBLE, 32'd5, 1'b1);           // touch while on
		send(OP_ACTIVITY, 32'd10, 1'b1);
		send(OP_POLL, 32'd10010, 1'b1);         // off
		send(OP_SHORT, 32'd10020, 1'b1);        // click without a press
		send(OP_PRESS, 32'd10030, 1'b1);
		send(OP_RELEASE, 32'd10100, 1'b1);      // ignored while recording
		send(OP_SHORT, 32'd10331, 1'b1);        // one tick too long
		send(OP_PRESS, 32'd10400, 1'b1);
		send(OP_SHORT, 32'd10700, 1'b1);        // longest tap: first tap
		send(OP_PRESS, 32'd10800, 1'b1);
		send(OP_LOST, 32'd10850, 1'b1);         // lost press clears the guard
		send(OP_PRESS, 32'd11000, 1'b1);
		send(OP_SHORT, 32'd11100, 1'b1);        // first tap
		send(OP_PRESS, 32'd11700, 1'b1);
		send(OP_SHORT, 32'd11801, 1'b1);        // window missed by one: new first tap
		send(OP_PRESS, 32'd12400, 1'b1);
		send(OP_SHORT, 32'd12501, 1'b1);        // gap equals window: wake
		send(OP_POLL, 32'd22501, 1'b1);         // off
		send(OP_DOUBLE, 32'd22600, 1'b1);       // double click wakes
		send(OP_POLL, 32'd32600, 1'b0);         // off
		send(OP_FORCE_ON, 32'hFFFF_FFFF, 1'b0); // force on from off

		// random scenes under several register settings
		tk = $urandom;
		apply_config(1'b1, 32'd0, 32'd0, 32'd0);
		run_random(120);
		apply_config(1'b1, 32'd40, 32'd15, 32'd30);
		run_random(150);
		apply_config(1'b0, 32'd100, 32'd10, 32'd10);
		run_random(80);
		apply_config(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_random(100);
		apply_config(1'b1, $urandom_range(1, 500), $urandom_range(0, 100),
			$urandom_range(0, 300));
		run_random(200);
		apply_config(RST_AUTO_OFF, RST_IDLE_TMO, RST_MAX_TAP, RST_TAP_WINDOW);
		run_random(130);

		pause_until_drained();
		repeat (10) @(posedge clk);

		$display("Sent %0d events over six register settings, %0d results checked.",
			sent_cnt, checked_cnt);
		$display("Backlight switched off %0d times and woken %0d times.", off_cnt, on_cnt);
		if (err_cnt == 0 && backlog == 0)
			$display("display_idle_off_tap_wake_core_tb passed");
		else
			$display("display_idle_off_tap_wake_core_tb failed");
		$finish;
	end

endmodule
